FILE: rtl/ows_pkg.sv
// Shared constants and codes for the 1-Wire ROM search engine.
`default_nettype none
package ows_pkg;

   localparam int ROM_BITS    = 64;
   localparam int FAMILY_BITS = 8;
   localparam int POS_W       = $clog2(ROM_BITS + 1);
   localparam int IDX_W       = $clog2(ROM_BITS);
   localparam int FDISC_W     = $clog2(FAMILY_BITS + 1);

   typedef enum logic [2:0] {
      REQ_RESET_SEARCH = 3'd0,
      REQ_TARGET_SETUP = 3'd1,
      REQ_FAMILY_SKIP  = 3'd2,
      REQ_BEGIN        = 3'd3,
      REQ_BIT_PAIR     = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_ACK   = 2'd0,
      ST_DIR   = 2'd1,
      ST_FOUND = 2'd2,
      ST_FAIL  = 2'd3
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/ows_if.sv
// Request and response channel interfaces of the ROM search engine.
`default_nettype none
interface ows_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic       presence_missing;
   logic       id_bit;
   logic       comp_bit;
   logic [7:0] family_byte;

   modport source (output valid, req_type, presence_missing, id_bit, comp_bit,
                   family_byte, input ready);
   modport sink (input valid, req_type, presence_missing, id_bit, comp_bit,
                 family_byte, output ready);
endinterface

interface ows_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        dir_valid;
   logic        dir_bit;
   logic [63:0] rom_id;
   logic        last_device;

   modport source (output valid, status, dir_valid, dir_bit, rom_id, last_device,
                   input ready);
   modport sink (input valid, status, dir_valid, dir_bit, rom_id, last_device,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/onewire_rom_search.sv
// Each accepted request word yields its response word from the response register.
// Throughput: one word per cycle while responses are taken; the response register lets a new request
// in whenever it is empty or being drained in the same cycle.
// The search state updates in the cycle the request is accepted.
// Synchronous active-high reset clears the search state, sets the bit
// position to one and empties the response register.
`default_nettype none
module onewire_rom_search
   import ows_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ows_req_if.sink     req_bus,
   ows_rsp_if.source   rsp_bus
);

   logic [ROM_BITS-1:0] rom_ff, rom_in;
   logic [POS_W-1:0]    last_disc_ff, last_disc_in;
   logic [FDISC_W-1:0]  fam_disc_ff, fam_disc_in;
   logic                last_dev_ff, last_dev_in;
   logic [POS_W-1:0]    bit_pos_ff, bit_pos_in;
   logic [POS_W-1:0]    last_zero_ff, last_zero_in;
   logic                searching_ff, searching_in;

   logic                rsp_valid_ff;
   status_type          status_ff, status_in;
   logic                dir_valid_ff, dir_valid_in;
   logic                dir_bit_ff, dir_bit_in;

   logic                accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      logic [IDX_W-1:0]    idx;
      logic                dir;
      logic [ROM_BITS-1:0] rom_tmp;
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      fam_disc_in  = fam_disc_ff;
      last_dev_in  = last_dev_ff;
      bit_pos_in   = bit_pos_ff;
      last_zero_in = last_zero_ff;
      searching_in = searching_ff;
      status_in    = ST_ACK;
      dir_valid_in = 1'b0;
      dir_bit_in   = 1'b0;
      idx          = IDX_W'(bit_pos_ff - POS_W'(1));
      dir          = 1'b0;
      rom_tmp      = rom_ff;
      case (req_code_type'(req_bus.req_type))
         REQ_RESET_SEARCH: begin
            last_disc_in = '0;
            fam_disc_in  = '0;
            last_dev_in  = 1'b0;
            searching_in = 1'b0;
            bit_pos_in   = POS_W'(1);
         end
         REQ_TARGET_SETUP: begin
            rom_in       = {{(ROM_BITS-FAMILY_BITS){1'b0}},
                            req_bus.family_byte[FAMILY_BITS-1:0]};
            last_disc_in = POS_W'(ROM_BITS);
            fam_disc_in  = '0;
            last_dev_in  = 1'b0;
            searching_in = 1'b0;
            bit_pos_in   = POS_W'(1);
         end
         REQ_FAMILY_SKIP: begin
            last_disc_in = POS_W'(fam_disc_ff);
            fam_disc_in  = '0;
            if (fam_disc_ff == '0) begin
               last_dev_in = 1'b1;
            end
         end
         REQ_BEGIN: begin
            bit_pos_in   = POS_W'(1);
            last_zero_in = '0;
            if (last_dev_ff || req_bus.presence_missing) begin
               last_disc_in = '0;
               fam_disc_in  = '0;
               last_dev_in  = 1'b0;
               searching_in = 1'b0;
               status_in    = ST_FAIL;
            end else begin
               searching_in = 1'b1;
            end
         end
         REQ_BIT_PAIR: begin
            if (searching_ff) begin
               if (req_bus.id_bit && req_bus.comp_bit) begin
                  // no device answered this slot: abandon the pass
                  searching_in = 1'b0;
                  last_disc_in = '0;
                  fam_disc_in  = '0;
                  last_dev_in  = 1'b0;
                  status_in    = ST_FAIL;
               end else begin
                  if (req_bus.id_bit != req_bus.comp_bit) begin
                     dir = req_bus.id_bit;
                  end else begin
                     // discrepancy: replay old path below the mark, take 1 at it
                     if (bit_pos_ff < last_disc_ff) begin
                        dir = rom_ff[idx];
                     end else begin
                        dir = (bit_pos_ff == last_disc_ff);
                     end
                     if (!dir) begin
                        last_zero_in = bit_pos_ff;
                        if (bit_pos_ff <= POS_W'(FAMILY_BITS)) begin
                           fam_disc_in = FDISC_W'(bit_pos_ff);
                        end
                     end
                  end
                  rom_tmp[idx] = dir;
                  rom_in       = rom_tmp;
                  dir_valid_in = 1'b1;
                  dir_bit_in   = dir;
                  status_in    = ST_DIR;
                  if (bit_pos_ff >= POS_W'(ROM_BITS)) begin
                     searching_in = 1'b0;
                     bit_pos_in   = POS_W'(1);
                     last_disc_in = last_zero_in;
                     if (last_zero_in == '0) begin
                        last_dev_in = 1'b1;
                     end
                     if (rom_tmp[FAMILY_BITS-1:0] == '0) begin
                        last_disc_in = '0;
                        fam_disc_in  = '0;
                        last_dev_in  = 1'b0;
                        status_in    = ST_FAIL;
                     end else begin
                        status_in = ST_FOUND;
                     end
                  end else begin
                     bit_pos_in = bit_pos_ff + POS_W'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_ff       <= '0;
         last_disc_ff <= '0;
         fam_disc_ff  <= '0;
         last_dev_ff  <= 1'b0;
         bit_pos_ff   <= POS_W'(1);
         last_zero_ff <= '0;
         searching_ff <= 1'b0;
      end else if (accept) begin
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         fam_disc_ff  <= fam_disc_in;
         last_dev_ff  <= last_dev_in;
         bit_pos_ff   <= bit_pos_in;
         last_zero_ff <= last_zero_in;
         searching_ff <= searching_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the response word until it is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         dir_valid_ff <= dir_valid_in;
         dir_bit_ff   <= dir_bit_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.dir_valid   = dir_valid_ff;
   assign rsp_bus.dir_bit     = dir_bit_ff;
   assign rsp_bus.rom_id      = rom_ff;
   assign rsp_bus.last_device = last_dev_ff;

endmodule
`default_nettype wire

FILE: rtl/ows_checker.sv
// Port-level assertions for the ROM search engine and their bind.
`default_nettype none
module ows_checker
   import ows_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   ows_rsp_if.source rsp_bus
);

   a_dir_bit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.dir_valid |-> !rsp_bus.dir_bit)
      else $error("dir_bit set without dir_valid");

   a_dir_status: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status == ST_DIR || rsp_bus.status == ST_FOUND)
      |-> rsp_bus.dir_valid)
      else $error("direction status without dir_valid");

   a_found_family: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status == ST_FOUND
      |-> rsp_bus.rom_id[FAMILY_BITS-1:0] != '0)
      else $error("found device with zero family field");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response word valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.rom_id))
      else $error("stalled response word changed");

endmodule

bind onewire_rom_search ows_checker u_ows_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_bus (rsp_bus)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the 1-Wire ROM search engine with a simulated device bus.
`timescale 1ns / 100ps

module testbench
   import ows_pkg::*;
();

   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          WORD_TARGET  = 1700;
   localparam int          HOLD_CYCLES  = 60;
   localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
   localparam logic [2:0]  REQ_SPARE_HI = 3'd7;
   localparam logic [63:0] FAMILY_MASK  = (64'd1 << FAMILY_BITS) - 64'd1;

   typedef struct {
      logic [2:0] kind;
      bit         absent;
      bit         id_bit;
      bit         cmp_bit;
      bit [7:0]   family;
   } search_req_type;

   typedef struct {
      status_type status;
      bit         dir_valid;
      bit         dir_bit;
      bit [63:0]  rom;
      bit         last_dev;
   } search_rsp_type;

   logic clock;
   logic reset;

   ows_req_if req_bus ();
   ows_rsp_if rsp_bus ();

   onewire_rom_search dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // search state mirrored from the engine
   bit [63:0] rom_img;
   bit [6:0]  disc_pos;
   bit [3:0]  family_disc;
   bit        found_last;
   bit [6:0]  bit_pos;
   bit [6:0]  zero_pos;
   bit        in_pass;

   search_rsp_type pending_rsp[$];
   search_rsp_type rsp_want;
   bit [63:0]      pool[$];
   bit             alive[8];

   int error_count;
   int cycle_count;
   int words_sent;
   int burst_left;
   bit offering;
   bit no_gaps;
   int hold_request;
   int hold_seen;
   int hold_left;
   int pat_cycle;
   int rx_mode;
   bit grant;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 50)
         $display("mismatch %s: got %h, expected %h at cycle %0d",
                  what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic void clear_disc();
      disc_pos    = '0;
      family_disc = '0;
      found_last  = 1'b0;
   endfunction

   function automatic void reset_search_state();
      rom_img  = '0;
      clear_disc();
      bit_pos  = 7'd1;
      zero_pos = '0;
      in_pass  = 1'b0;
   endfunction

   // Advance the mirrored state by one request word and return its response.
   function automatic search_rsp_type apply_search_word(input search_req_type w);
      search_rsp_type r;
      bit [6:0]       pos;
      bit [63:0]      m;
      bit             dir;
      r.status    = ST_ACK;
      r.dir_valid = 1'b0;
      r.dir_bit   = 1'b0;
      case (w.kind)
         REQ_RESET_SEARCH: begin
            clear_disc();
            in_pass = 1'b0;
            bit_pos = 7'd1;
         end
         REQ_TARGET_SETUP: begin
            rom_img     = 64'(w.family) & FAMILY_MASK;
            disc_pos    = 7'(ROM_BITS);
            family_disc = '0;
            found_last  = 1'b0;
            in_pass     = 1'b0;
            bit_pos     = 7'd1;
         end
         REQ_FAMILY_SKIP: begin
            disc_pos    = 7'(family_disc);
            family_disc = '0;
            if (disc_pos == 0)
               found_last = 1'b1;
         end
         REQ_BEGIN: begin
            bit_pos  = 7'd1;
            zero_pos = '0;
            in_pass  = 1'b0;
            if (found_last || w.absent) begin
               clear_disc();
               r.status = ST_FAIL;
            end else begin
               in_pass = 1'b1;
            end
         end
         REQ_BIT_PAIR: begin
            if (in_pass && w.id_bit && w.cmp_bit) begin
               in_pass = 1'b0;
               clear_disc();
               r.status = ST_FAIL;
            end else if (in_pass) begin
               pos = bit_pos;
               m   = 64'd1 << 6'(pos - 7'd1);
               if (w.id_bit != w.cmp_bit) begin
                  dir = w.id_bit;
               end else begin
                  if (pos < disc_pos)
                     dir = (rom_img & m) != 0;
                  else
                     dir = (pos == disc_pos);
                  if (!dir) begin
                     zero_pos = pos;
                     if (pos <= FAMILY_BITS)
                        family_disc = 4'(pos);
                  end
               end
               if (dir)
                  rom_img = rom_img | m;
               else
                  rom_img = rom_img & ~m;
               r.dir_valid = 1'b1;
               r.dir_bit   = dir;
               r.status    = ST_DIR;
               if (pos >= ROM_BITS) begin
                  in_pass  = 1'b0;
                  bit_pos  = 7'd1;
                  disc_pos = zero_pos;
                  if (disc_pos == 0)
                     found_last = 1'b1;
                  if ((rom_img & FAMILY_MASK) == 0) begin
                     clear_disc();
                     r.status = ST_FAIL;
                  end else begin
                     r.status = ST_FOUND;
                  end
               end else begin
                  bit_pos = pos + 7'd1;
               end
            end
         end
         default: ;
      endcase
      r.rom      = rom_img;
      r.last_dev = found_last;
      return r;
   endfunction

   task automatic drop_offer();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Offer one word, wait for acceptance, record its response, then pace.
   task automatic send_word(input logic [2:0] kind, input bit absent, input bit idb,
                            input bit cmpb, input bit [7:0] fam,
                            output search_rsp_type r);
      search_req_type w;
      int             gap;
      w.kind    = kind;
      w.absent  = absent;
      w.id_bit  = idb;
      w.cmp_bit = cmpb;
      w.family  = fam;
      req_bus.valid            <= 1'b1;
      req_bus.req_type         <= kind;
      req_bus.presence_missing <= absent;
      req_bus.id_bit           <= idb;
      req_bus.comp_bit         <= cmpb;
      req_bus.family_byte      <= fam;
      offering = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = apply_search_word(w);
      pending_rsp.push_back(r);
      words_sent++;
      if (!no_gaps) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               drop_offer();
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      drop_offer();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic send_noise();
      search_rsp_type r;
      send_word(3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), r);
   endtask

   // One search pass over the simulated bus; the devices answer by wired-AND.
   task automatic run_pass(output bit over);
      search_rsp_type r;
      bit             idb;
      bit             cmpb;
      over = 1'b0;
      send_word(REQ_BEGIN,
                (pool.size() == 0) ? 1'($urandom) : ($urandom_range(0, 39) == 0),
                1'($urandom), 1'($urandom), 8'($urandom), r);
      if (r.status == ST_FAIL) begin
         over = 1'b1;
         return;
      end
      for (int j = 0; j < pool.size(); j++)
         alive[j] = 1'b1;
      for (int i = 0; i < ROM_BITS; i++) begin
         idb  = 1'b1;
         cmpb = 1'b1;
         for (int j = 0; j < pool.size(); j++) begin
            if (alive[j]) begin
               if (pool[j][i])
                  cmpb = 1'b0;
               else
                  idb = 1'b0;
            end
         end
         send_word(REQ_BIT_PAIR, 1'($urandom), idb, cmpb, 8'($urandom), r);
         if (!r.dir_valid) begin
            over = 1'b1;
            return;
         end
         for (int j = 0; j < pool.size(); j++)
            if (pool[j][i] != r.dir_bit)
               alive[j] = 1'b0;
      end
      over = r.last_dev || (r.status == ST_FAIL);
   endtask

   task automatic test_idle_requests();
      search_rsp_type r;
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00, r);
      for (logic [3:0] k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
         send_word(k[2:0], 1'b1, 1'b1, 1'b1, 8'hFF, r);
      send_word(REQ_RESET_SEARCH, 1'b1, 1'b1, 1'b1, 8'hFF, r);
      // skip with no family discrepancy marks the last device
      send_word(REQ_FAMILY_SKIP, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_TARGET_SETUP, 1'b0, 1'b0, 1'b0, 8'hFF, r);
      send_word(REQ_BEGIN, 1'b1, 1'b0, 1'b0, 8'h00, r);
   endtask

   task automatic test_pair_handling();
      search_rsp_type r;
      send_word(REQ_TARGET_SETUP, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b1, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b1, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b1, 1'b1, 8'h00, r);
      send_word(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BEGIN, 1'b0, 1'b1, 1'b1, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b1, 1'b0, 8'h00, r);
      send_word(REQ_FAMILY_SKIP, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_TARGET_SETUP, 1'b0, 1'b0, 1'b0, 8'hA5, r);
      send_word(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b1, 8'h00, r);
      send_word(REQ_RESET_SEARCH, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BIT_PAIR, 1'b0, 1'b0, 1'b0, 8'h00, r);
   endtask

   // Hold the response side off while words keep coming, so the engine stalls.
   task automatic test_backpressure();
      search_rsp_type r;
      bit             idb;
      drain();
      no_gaps = 1'b1;
      hold_request++;
      send_word(REQ_RESET_SEARCH, 1'b0, 1'b0, 1'b0, 8'h00, r);
      send_word(REQ_BEGIN, 1'b0, 1'b0, 1'b0, 8'h00, r);
      repeat (30) begin
         idb = 1'($urandom);
         send_word(REQ_BIT_PAIR, 1'($urandom), idb, idb ? 1'b0 : 1'($urandom),
                   8'($urandom), r);
      end
      no_gaps = 1'b0;
      drain();
   endtask

   task automatic test_device_enumeration(input bit zero_family);
      search_rsp_type r;
      int             count;
      int             passes;
      bit [63:0]      base;
      bit             over;
      pool.delete();
      count = zero_family ? $urandom_range(1, 4) : $urandom_range(0, 5);
      base  = {$urandom, $urandom};
      if (zero_family || $urandom_range(0, 7) == 0)
         base[7:0] = 8'h00;
      for (int k = 0; k < count; k++)
         pool.push_back(base ^ ({$urandom, $urandom} <<
                        (zero_family ? $urandom_range(8, 63) : $urandom_range(0, 63))));
      if ($urandom_range(0, 3) == 0)
         send_word(REQ_TARGET_SETUP, 1'($urandom), 1'($urandom), 1'($urandom),
                   (count != 0) ? pool[$urandom_range(0, count - 1)][7:0] : 8'($urandom), r);
      else
         send_word(REQ_RESET_SEARCH, 1'($urandom), 1'($urandom), 1'($urandom),
                   8'($urandom), r);
      passes = 0;
      over   = 1'b0;
      while (!over && passes < count + 3) begin
         run_pass(over);
         passes++;
         if (!over && $urandom_range(0, 5) == 0)
            send_word(REQ_FAMILY_SKIP, 1'($urandom), 1'($urandom), 1'($urandom),
                      8'($urandom), r);
      end
   endtask

   task automatic test_broken_passes();
      search_rsp_type r;
      bit             idb;
      bit             cmpb;
      send_word(REQ_BEGIN, 1'b0, 1'($urandom), 1'($urandom), 8'($urandom), r);
      repeat ($urandom_range(1, 70)) begin
         if ($urandom_range(0, 11) == 0) begin
            send_noise();
         end else begin
            if ($urandom_range(0, 11) == 0) begin
               idb  = 1'b1;
               cmpb = 1'b1;
            end else begin
               idb  = 1'($urandom);
               cmpb = idb ? 1'b0 : 1'($urandom);
            end
            send_word(REQ_BIT_PAIR, 1'($urandom), idb, cmpb, 8'($urandom), r);
         end
      end
   endtask

   task automatic test_noise();
      repeat ($urandom_range(1, 8))
         send_noise();
   endtask

   // Receiver: stall pattern changes every so often; long hold-offs on request.
   always @(posedge clock) begin
      if (hold_seen != hold_request) begin
         hold_seen = hold_request;
         hold_left = HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left--;
      end
      pat_cycle++;
      if (pat_cycle % 97 == 0)
         rx_mode = $urandom_range(0, 3);
      case (rx_mode)
         0:       grant = 1'b1;
         1:       grant = 1'($urandom);
         2:       grant = ($urandom_range(0, 3) == 0);
         default: grant = (pat_cycle % 4 != 0);
      endcase
      rsp_bus.ready <= grant && (hold_left == 0);
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response word with nothing expected", rsp_bus.rom_id, '0);
         end else begin
            rsp_want = pending_rsp.pop_front();
            if (rsp_bus.status !== rsp_want.status)
               report_mismatch("status", 64'(rsp_bus.status), 64'(rsp_want.status));
            if (rsp_bus.dir_valid !== rsp_want.dir_valid)
               report_mismatch("dir_valid", 64'(rsp_bus.dir_valid), 64'(rsp_want.dir_valid));
            if (rsp_bus.dir_bit !== rsp_want.dir_bit)
               report_mismatch("dir_bit", 64'(rsp_bus.dir_bit), 64'(rsp_want.dir_bit));
            if (rsp_bus.rom_id !== rsp_want.rom)
               report_mismatch("rom_id", rsp_bus.rom_id, rsp_want.rom);
            if (rsp_bus.last_device !== rsp_want.last_dev)
               report_mismatch("last_device", 64'(rsp_bus.last_device),
                               64'(rsp_want.last_dev));
         end
      end
   end

   initial begin
      int wait_cycles;
      int pick;
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.req_type         = REQ_RESET_SEARCH;
      req_bus.presence_missing = 1'b0;
      req_bus.id_bit           = 1'b0;
      req_bus.comp_bit         = 1'b0;
      req_bus.family_byte      = 8'h00;
      words_sent   = 0;
      burst_left   = 0;
      offering     = 1'b0;
      no_gaps      = 1'b0;
      hold_request = 0;
      reset_search_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_pair_handling();
      drain();
      test_backpressure();
      test_device_enumeration(1'b1);
      test_device_enumeration(1'b0);
      drain();
      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            test_device_enumeration(1'b0);
         else if (pick < 8)
            test_broken_passes();
         else
            test_noise();
         if ($urandom_range(0, 9) == 0)
            drain();
      end
      test_backpressure();

      drop_offer();
      for (wait_cycles = 0; pending_rsp.size() != 0 && wait_cycles < 5000; wait_cycles++)
         @(posedge clock);
      repeat (3) @(posedge clock);
      if (pending_rsp.size() != 0)
         report_mismatch("response words never arrived", 64'(pending_rsp.size()), '0);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
